>>> src/tuc_pkg.sv
`timescale 1ns / 1ps

package tuc_pkg;

    // default number of tags in the bank
    localparam int TAG_COUNT_DEF = 16;

    // field widths
    localparam int OP_W    = 3;
    localparam int TAG_W   = 8;
    localparam int BYTES_W = 32;
    localparam int CNT_W   = 64;
    localparam int FB_W    = 4;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    // opcodes
    localparam logic [OP_W-1:0] OP_ALLOC = 3'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 3'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 3'd2;
    localparam logic [OP_W-1:0] OP_TOTAL = 3'd3;
    localparam logic [OP_W-1:0] OP_RSTPK = 3'd4;

    // register index of the fallback tag
    localparam logic REG_FALLBACK = 1'b0;

    // one row of the counter memory
    typedef struct packed {
        logic [CNT_W-1:0] held;
        logic [CNT_W-1:0] peak;
        logic [CNT_W-1:0] allocs;
        logic [CNT_W-1:0] frees;
    } row_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FINISH
    } state_t;

endpackage

>>> src/tagged_usage_counters_with_peak.sv
`timescale 1ns / 1ps

// Bank of per-tag usage counters with peak tracking.
// Input channel s_*: opcode, tag_index, byte_count; valid/ready handshake.
// Result channel m_*: current_bytes, peak_bytes, alloc_count, free_count,
// one transaction for each query or total, none for the other opcodes.
// APB port: fallback_tag at byte address 0, used for tags at or above
// TAG_COUNT (the last tag if the fallback is itself out of range).
// All counters live in one memory row per tag with a registered read port;
// a shared read-modify-write path updates one row a cycle.
// Allocate and free read the row at accept, then write the update. Query
// reads the row, holds it, then loads the output register. Total and
// reset-peaks walk every row, one per cycle; a total then posts its sum.
// s_ready is high only while the sequencer is idle.
// At reset all rows read as zero through per-row valid bits, cleared at
// once; no clearing pass is needed. The fallback tag resets to 0.
// A result waits in the output register while the receiver stalls; the
// next transaction is still accepted, and only a later query or total
// holds at its end until the output register is free.
module tagged_usage_counters_with_peak
    import tuc_pkg::*;
#(
    parameter int TAG_COUNT = TAG_COUNT_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    // input transactions
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [OP_W-1:0]     s_opcode,
    input  logic [TAG_W-1:0]    s_tag_index,
    input  logic [BYTES_W-1:0]  s_byte_count,
    // result transactions
    output logic                m_valid,
    input  logic                m_ready,
    output logic [CNT_W-1:0]    m_current_bytes,
    output logic [CNT_W-1:0]    m_peak_bytes,
    output logic [CNT_W-1:0]    m_alloc_count,
    output logic [CNT_W-1:0]    m_free_count,
    // configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready
);

    localparam int TW = (TAG_COUNT > 1) ? $clog2(TAG_COUNT) : 1;

    state_t             state_reg, state_next;
    logic [OP_W-1:0]    op_reg, op_next;
    logic [TW-1:0]      idx_reg, idx_next;
    logic [BYTES_W-1:0] bytes_reg, bytes_next;
    row_t               acc_reg, acc_next;
    row_t               out_reg, out_next;
    logic               m_valid_reg, m_valid_next;
    logic [FB_W-1:0]    fallback_reg;
    logic [TAG_COUNT-1:0] valid_reg;

    row_t               mem [TAG_COUNT];
    row_t               rd_row_reg;
    logic               rd_vld_reg;

    logic [TW-1:0]      rd_addr;
    logic               we;
    row_t               wr_row;
    row_t               row;
    logic [TW-1:0]      pick;
    logic               last;
    logic               accept;
    logic               out_free;
    logic               op_known;
    logic [CNT_W-1:0]   held_sum;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[ADDR_W-1] == REG_FALLBACK)
                    ? {{(DATA_W-FB_W){1'b0}}, fallback_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fallback_reg <= '0;
        end else if (psel && penable && pwrite && pready
                     && paddr[ADDR_W-1] == REG_FALLBACK) begin
            fallback_reg <= pwdata[FB_W-1:0];
        end
    end

    // tag selection with fallback
    always_comb begin
        if ({1'b0, s_tag_index} < 9'(TAG_COUNT)) begin
            pick = TW'(s_tag_index);
        end else if ({5'b0, fallback_reg} < 9'(TAG_COUNT)) begin
            pick = TW'(fallback_reg);
        end else begin
            pick = TW'(TAG_COUNT - 1);
        end
    end

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign last     = (idx_reg == TW'(TAG_COUNT - 1));
    assign op_known = (s_opcode == OP_ALLOC) || (s_opcode == OP_FREE)
                      || (s_opcode == OP_QUERY) || (s_opcode == OP_TOTAL)
                      || (s_opcode == OP_RSTPK);

    // rows never written read as zero
    assign row = rd_vld_reg ? rd_row_reg : '0;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && op_known) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (op_reg)
                    OP_QUERY: state_next = ST_FINISH;
                    OP_TOTAL: state_next = last ? ST_FINISH : ST_EXEC;
                    OP_RSTPK: state_next = last ? ST_IDLE : ST_EXEC;
                    default:  state_next = ST_IDLE;
                endcase
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        op_next      = op_reg;
        idx_next     = idx_reg;
        bytes_next   = bytes_reg;
        acc_next     = acc_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg;
        rd_addr      = idx_reg;
        we           = 1'b0;
        wr_row       = row;
        held_sum     = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                // capture the transaction and start the row read
                if (accept) begin
                    op_next    = s_opcode;
                    bytes_next = s_byte_count;
                    acc_next   = '0;
                    if (s_opcode == OP_TOTAL || s_opcode == OP_RSTPK) begin
                        idx_next = '0;
                    end else begin
                        idx_next = pick;
                    end
                    rd_addr = idx_next;
                end
            end
            ST_EXEC: begin
                case (op_reg)
                    OP_ALLOC: begin
                        held_sum      = row.held + {{(CNT_W-BYTES_W){1'b0}}, bytes_reg};
                        wr_row.held   = held_sum;
                        wr_row.allocs = row.allocs + 64'd1;
                        if (held_sum > row.peak) begin
                            wr_row.peak = held_sum;
                        end
                        we = 1'b1;
                    end
                    OP_FREE: begin
                        wr_row.held  = row.held - {{(CNT_W-BYTES_W){1'b0}}, bytes_reg};
                        wr_row.frees = row.frees + 64'd1;
                        we = 1'b1;
                    end
                    OP_QUERY: begin
                        acc_next = row;
                    end
                    OP_TOTAL: begin
                        acc_next.held   = acc_reg.held + row.held;
                        acc_next.peak   = acc_reg.peak + row.peak;
                        acc_next.allocs = acc_reg.allocs + row.allocs;
                        acc_next.frees  = acc_reg.frees + row.frees;
                    end
                    OP_RSTPK: begin
                        wr_row.peak = row.held;
                        we = 1'b1;
                    end
                    default: begin
                    end
                endcase
                // walk to the next row while this one is written back or summed
                if (op_reg == OP_TOTAL || op_reg == OP_RSTPK) begin
                    idx_next = last ? '0 : idx_reg + TW'(1);
                    rd_addr  = idx_next;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    out_next     = acc_reg;
                    m_valid_next = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            valid_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (we) begin
                valid_reg[idx_reg] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        op_reg    <= op_next;
        idx_reg   <= idx_next;
        bytes_reg <= bytes_next;
        acc_reg   <= acc_next;
        out_reg   <= out_next;
    end

    // counter memory, one write and one registered read a cycle
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[idx_reg] <= wr_row;
        end
        rd_row_reg <= mem[rd_addr];
        rd_vld_reg <= valid_reg[rd_addr] && !(we && idx_reg == rd_addr) ? valid_reg[rd_addr]
                      : valid_reg[rd_addr];
    end

    assign m_valid         = m_valid_reg;
    assign m_current_bytes = out_reg.held;
    assign m_peak_bytes    = out_reg.peak;
    assign m_alloc_count   = out_reg.allocs;
    assign m_free_count    = out_reg.frees;

endmodule
